// ===== rtl/fslt_pkg.sv =====
// Package for the flow session loss tracker.
// Holds the channel item types, the probe and write bundles that travel along
// the cell chain, and shared constants. No dependencies.
package fslt_pkg;

  // Default table depth and the index width that covers the largest table
  localparam int unsigned MAX_SESSIONS_DEF = 16;
  localparam int unsigned SLOT_IDX_W       = 8;
  localparam int unsigned ENTRY_SLOT_W     = 4;

  // Sequence number that ends a session
  localparam logic [31:0] END_SEQUENCE = 32'hffff_ffff;

  // One received datagram
  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] sequence_number;
    logic [15:0] datagram_bytes;
  } datagram_t;

  // One result
  typedef struct packed {
    logic [ENTRY_SLOT_W-1:0] entry_slot;
    logic                    opened_new;
    logic                    closed_now;
    logic                    table_full;
    logic [31:0]             bytes_total;
    logic [31:0]             messages_total;
    logic [31:0]             messages_lost;
    logic [31:0]             sessions_opened;
    logic [31:0]             datagrams_seen;
  } report_t;

  // Lookup probe, passed from cell to cell
  typedef struct packed {
    logic                  active;
    logic [31:0]           address;
    logic [15:0]           port;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic [31:0]           bytes;
    logic [31:0]           messages;
    logic [31:0]           lost;
    logic [31:0]           last_sequence;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
  } probe_t;

  // Entry update, broadcast to all cells
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  valid;
    logic [31:0]           address;
    logic [15:0]           port;
    logic [31:0]           bytes;
    logic [31:0]           messages;
    logic [31:0]           lost;
    logic [31:0]           last_sequence;
  } write_t;

endpackage

// ===== rtl/fslt_stream_if.sv =====
// Valid/ready stream channel for the flow session loss tracker.
// The payload type is a parameter; used with fslt_pkg item types.
interface fslt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fslt_cell.sv =====
// One session table entry with its stage of the lookup chain.
// Depends on fslt_pkg (probe_t, write_t).
module fslt_cell import fslt_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  probe_t probe_prev,
  output probe_t probe,
  input  write_t wr
);

  localparam logic [SLOT_IDX_W-1:0] OWN_IDX = SLOT_IDX_W'(CELL_IDX);

  logic        valid;
  logic [31:0] address;
  logic [15:0] port;
  logic [31:0] bytes;
  logic [31:0] messages;
  logic [31:0] lost;
  logic [31:0] last_sequence;
  probe_t      probe_next;
  logic        wr_here;

  assign wr_here = wr.en && (wr.idx == OWN_IDX);

  // Check this entry against the passing probe
  always_comb begin
    probe_next = probe_prev;
    if (probe_prev.active) begin
      if (valid) begin
        if (!probe_prev.hit && address == probe_prev.address
            && port == probe_prev.port) begin
          probe_next.hit           = 1'b1;
          probe_next.hit_idx       = OWN_IDX;
          probe_next.bytes         = bytes;
          probe_next.messages      = messages;
          probe_next.lost          = lost;
          probe_next.last_sequence = last_sequence;
        end
      end else if (!probe_prev.free_found) begin
        probe_next.free_found = 1'b1;
        probe_next.free_idx   = OWN_IDX;
      end
    end
  end

  // Hand the probe on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= '0;
    end else begin
      probe <= probe_next;
    end
  end

  // Entry valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= wr.valid;
    end
  end

  // Entry contents
  always_ff @(posedge clk) begin
    if (wr_here) begin
      address       <= wr.address;
      port          <= wr.port;
      bytes         <= wr.bytes;
      messages      <= wr.messages;
      lost          <= wr.lost;
      last_sequence <= wr.last_sequence;
    end
  end

endmodule

// ===== rtl/flow_session_loss_tracker.sv =====
// Top level of the flow session loss tracker: chain of table cells plus the
// sequencer that injects probes, updates entries and drives the result.
// Depends on fslt_pkg, fslt_stream_if and fslt_cell.
//
//   channel    dir   payload      transfer when
//   datagram   in    datagram_t   datagram.valid && datagram.ready
//   report     out   report_t     report.valid && report.ready
//
// A datagram's probe is registered at the head, walks the cell chain one cell
// per cycle and is captured at the end; the finish step then writes the entry
// and registers the result. No new datagram is taken until that step is done.
// Reset marks every entry free and clears both counters.
// A stalled result holds the finish step; a new datagram is taken while the
// last result still waits.
module flow_session_loss_tracker import fslt_pkg::*; #(
  parameter int unsigned MAX_SESSIONS = MAX_SESSIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  fslt_stream_if.sink          datagram,
  fslt_stream_if.source        report
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]  state;
  probe_t      chain [0:MAX_SESSIONS];
  probe_t      head;
  probe_t      done_probe;
  logic [31:0] pend_seq;
  logic [15:0] pend_len;
  logic [31:0] session_counter;
  logic [31:0] datagram_counter;
  write_t      wr;
  report_t     result;
  logic        in_fire;
  logic        finish_fire;

  // Finish-step values
  logic                    alloc;
  logic                    full;
  logic                    is_end;
  logic [SLOT_IDX_W-1:0]   idx;
  logic [SLOT_IDX_W+3:0]   idx_ext;
  logic [31:0]             base_bytes;
  logic [31:0]             base_messages;
  logic [31:0]             base_lost;
  logic [31:0]             base_last;
  logic [31:0]             new_bytes;
  logic [31:0]             new_messages;
  logic [31:0]             new_lost;
  logic [31:0]             session_counter_next;
  logic [31:0]             datagram_counter_next;

  assign datagram.ready = (state == ST_IDLE);
  assign in_fire        = datagram.valid && datagram.ready;
  assign finish_fire    = (state == ST_FINISH) && (!report.valid || report.ready);

  // Probe injection at the head of the chain; lookup fields stay clear from reset
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head.active     <= in_fire;
      head.address    <= datagram.data.source_address;
      head.port       <= datagram.data.source_port;
    end
  end

  // Datagram fields not needed by the cells
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_seq <= datagram.data.sequence_number;
      pend_len <= datagram.data.datagram_bytes;
    end
  end

  // Cell chain
  assign chain[0] = head;
  for (genvar g = 0; g < MAX_SESSIONS; g++) begin : g_cell
    fslt_cell #(.CELL_IDX(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_prev(chain[g]),
      .probe     (chain[g+1]),
      .wr        (wr)
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) state <= ST_WALK;
        end
        ST_WALK: begin
          if (chain[MAX_SESSIONS].active) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_fire) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Probe leaving the chain
  always_ff @(posedge clk) begin
    if (state == ST_WALK && chain[MAX_SESSIONS].active) begin
      done_probe <= chain[MAX_SESSIONS];
    end
  end

  // Entry update and result
  always_comb begin
    alloc   = !done_probe.hit && done_probe.free_found;
    full    = !done_probe.hit && !done_probe.free_found;
    is_end  = (pend_seq == END_SEQUENCE);
    idx     = done_probe.hit ? done_probe.hit_idx : done_probe.free_idx;
    idx_ext = {4'b0, idx};

    base_bytes    = done_probe.hit ? done_probe.bytes         : 32'd0;
    base_messages = done_probe.hit ? done_probe.messages      : 32'd0;
    base_lost     = done_probe.hit ? done_probe.lost          : 32'd0;
    base_last     = done_probe.hit ? done_probe.last_sequence : 32'd0;

    new_bytes    = base_bytes + {16'b0, pend_len};
    new_messages = base_messages + 32'd1;
    new_lost     = base_lost + (pend_seq - base_last - 32'd1);

    session_counter_next  = session_counter + {31'b0, alloc};
    datagram_counter_next = datagram_counter + 32'd1;

    wr.en            = finish_fire && !full;
    wr.idx           = idx;
    wr.valid         = !is_end;
    wr.address       = done_probe.address;
    wr.port          = done_probe.port;
    wr.bytes         = new_bytes;
    wr.messages      = new_messages;
    wr.lost          = new_lost;
    wr.last_sequence = pend_seq;

    result                 = '0;
    result.table_full      = full;
    result.sessions_opened = session_counter_next;
    result.datagrams_seen  = datagram_counter_next;
    if (!full) begin
      result.entry_slot = idx_ext[ENTRY_SLOT_W-1:0];
      result.opened_new = alloc;
      result.closed_now = is_end;
      if (is_end) begin
        result.bytes_total    = base_bytes;
        result.messages_total = base_messages;
        result.messages_lost  = base_lost;
      end else begin
        result.bytes_total    = new_bytes;
        result.messages_total = new_messages;
        result.messages_lost  = new_lost;
      end
    end
  end

  // Running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      session_counter  <= 32'd0;
      datagram_counter <= 32'd0;
    end else if (finish_fire) begin
      session_counter  <= session_counter_next;
      datagram_counter <= datagram_counter_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (finish_fire) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      report.data <= result;
    end
  end

endmodule
